// ===== hw/rtl/dd_odom_pkg.sv =====
// Shared constants and helpers for the differential-drive odometry block.
// Holds field widths, angle constants, the CORDIC arctangent table and saturation.
// No dependencies.
package dd_odom_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_RUN   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    localparam int SCALE_W = 24;
    localparam int ENC_W   = 32;
    localparam int HEAD_W  = 24;
    localparam int POS_W   = 40;

    localparam logic [24:0] FULL_TURN     = 25'd92160;
    localparam logic [24:0] QUARTER_TURN  = 25'd23040;
    localparam logic [24:0] HALF_TURN     = 25'd46080;
    localparam logic [24:0] THREE_QUARTER = 25'd69120;
    localparam logic signed [32:0] CORDIC_KINV = 33'sd652032874;

    localparam logic signed [43:0] Q40_MAX = 44'sd549755813887;
    localparam logic signed [43:0] Q40_MIN = -44'sd549755813888;

    localparam logic [2:0] ADDR_HIGH_SCALE = 3'd0;
    localparam logic [2:0] ADDR_LOW_SCALE  = 3'd4;

    // Arctangent of 2^-i in degrees, Q.24, rounded.
    function automatic logic signed [32:0] atan_q24(input logic [4:0] idx);
        logic signed [32:0] v;
        case (idx)
            5'd0:  v = 33'sd754974720;
            5'd1:  v = 33'sd445687602;
            5'd2:  v = 33'sd235489088;
            5'd3:  v = 33'sd119537938;
            5'd4:  v = 33'sd60000934;
            5'd5:  v = 33'sd30029717;
            5'd6:  v = 33'sd15018523;
            5'd7:  v = 33'sd7509720;
            5'd8:  v = 33'sd3754917;
            5'd9:  v = 33'sd1877466;
            5'd10: v = 33'sd938734;
            5'd11: v = 33'sd469367;
            5'd12: v = 33'sd234684;
            5'd13: v = 33'sd117342;
            5'd14: v = 33'sd58671;
            5'd15: v = 33'sd29335;
            5'd16: v = 33'sd14668;
            5'd17: v = 33'sd7334;
            5'd18: v = 33'sd3667;
            5'd19: v = 33'sd1833;
            5'd20: v = 33'sd917;
            5'd21: v = 33'sd458;
            5'd22: v = 33'sd229;
            5'd23: v = 33'sd115;
            5'd24: v = 33'sd57;
            5'd25: v = 33'sd29;
            5'd26: v = 33'sd14;
            5'd27: v = 33'sd7;
            5'd28: v = 33'sd4;
            5'd29: v = 33'sd2;
            5'd30: v = 33'sd1;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

    // Clamp a widened value to the 40-bit signed range.
    function automatic logic signed [39:0] sat40(input logic signed [43:0] v);
        logic signed [43:0] c;
        if (v > Q40_MAX) begin
            c = Q40_MAX;
        end else if (v < Q40_MIN) begin
            c = Q40_MIN;
        end else begin
            c = v;
        end
        return c[39:0];
    endfunction

endpackage

// ===== hw/rtl/differential_drive_odometry.sv =====
// Differential-drive dead-reckoning odometry, top level.
// Depends on dd_odom_pkg for constants, the arctangent table and saturation.
//
// Usage:
//   s_ channel: one request per control tick (mode, encoders, heading, gear).
//   m_ channel: one result per request: x, y and both wheel totals after it.
//   APB port: high_gear_scale at 0x0, low_gear_scale at 0x4, write while idle.
// Sequence:
//   An update request runs a bit-serial scale multiply, a heading reduction,
//   CORDIC_STEPS rotation steps (at most 32), a bit-serial projection and a
//   finishing state, in that order. The serial multipliers and the single
//   CORDIC stage are reused for every update request.
//   A zero request (mode 1) goes straight to the finishing state.
//   One request is worked on at a time; the next is taken while a result
//   still waits on m_ready, and its finish waits until the result is taken.
// Reset:
//   aresetn low clears positions, totals, latched encoders and the request
//   in flight, and loads both scale registers with 1.0 (65536).
module differential_drive_odometry (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_mode,
    input  logic signed [dd_odom_pkg::ENC_W-1:0]    s_left_encoder,
    input  logic signed [dd_odom_pkg::ENC_W-1:0]    s_right_encoder,
    input  logic signed [dd_odom_pkg::HEAD_W-1:0]   s_heading_deg,
    input  logic                                    s_gear_high,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [dd_odom_pkg::POS_W-1:0]    m_x_position,
    output logic signed [dd_odom_pkg::POS_W-1:0]    m_y_position,
    output logic signed [dd_odom_pkg::POS_W-1:0]    m_left_total,
    output logic signed [dd_odom_pkg::POS_W-1:0]    m_right_total,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [2:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import dd_odom_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SIDE    = 6'b000010,
        ST_REDUCE  = 6'b000100,
        ST_ROTATE  = 6'b001000,
        ST_PROJECT = 6'b010000,
        ST_FINISH  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] cnt_reg;

    logic [SCALE_W-1:0] high_scale_reg, low_scale_reg, scale_reg;
    logic zero_reg;
    logic signed [ENC_W-1:0] lat_left_reg, lat_right_reg;
    logic signed [ENC_W-1:0] last_left_reg, last_right_reg;
    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg, sum_left_reg, sum_right_reg;
    logic out_valid_reg;

    logic signed [32:0] diff_l_reg, diff_r_reg;
    logic signed [56:0] acc_l_reg, acc_r_reg;
    logic signed [POS_W-1:0] dl_reg, dr_reg;

    logic [24:0] hmag_reg;
    logic        hneg_reg, flip_reg;
    logic signed [32:0] cx_reg, cy_reg, cz_reg;

    logic [39:0] amag_reg;
    logic [31:0] cmag_reg, smag_reg;
    logic        negx_reg, negy_reg;
    logic [71:0] prod_x_reg, prod_y_reg;

    // Configuration port: writes and reads of the scale registers.
    assign pready = 1'b1;
    always_comb begin
        case (paddr)
            ADDR_HIGH_SCALE: prdata = {8'd0, high_scale_reg};
            ADDR_LOW_SCALE:  prdata = {8'd0, low_scale_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_scale_reg <= SCALE_W'(65536);
            low_scale_reg  <= SCALE_W'(65536);
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_HIGH_SCALE) begin
                high_scale_reg <= pwdata[SCALE_W-1:0];
            end else if (paddr == ADDR_LOW_SCALE) begin
                low_scale_reg <= pwdata[SCALE_W-1:0];
            end
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = out_valid_reg;
    assign m_x_position  = pos_x_reg;
    assign m_y_position  = pos_y_reg;
    assign m_left_total  = sum_left_reg;
    assign m_right_total = sum_right_reg;

    // Side change rounding after the serial multiply; saturated when stored.
    logic signed [56:0] rnd_l, rnd_r;
    logic signed [40:0] shl, shr;
    assign rnd_l = acc_l_reg + 57'sd32768;
    assign rnd_r = acc_r_reg + 57'sd32768;
    assign shl   = rnd_l[56:16];
    assign shr   = rnd_r[56:16];

    // Heading reduction step and fold into a half circle.
    logic [2:0]  red_k;
    logic [24:0] red_sub, ang_mod, ang_pos;
    logic signed [25:0] ang_fold;
    logic        fold_flip;
    assign red_k   = 3'd6 - cnt_reg[2:0];
    assign red_sub = FULL_TURN << red_k;
    always_comb begin
        ang_mod = hmag_reg;
        if (hmag_reg >= red_sub) begin
            ang_mod = hmag_reg - red_sub;
        end
        ang_pos = (hneg_reg && (ang_mod != 25'd0)) ? (FULL_TURN - ang_mod) : ang_mod;
        fold_flip = 1'b0;
        ang_fold  = $signed({1'b0, ang_pos});
        if ((ang_pos > QUARTER_TURN) && (ang_pos < THREE_QUARTER)) begin
            ang_fold  = $signed({1'b0, ang_pos}) - $signed({1'b0, HALF_TURN});
            fold_flip = 1'b1;
        end else if (ang_pos >= THREE_QUARTER) begin
            ang_fold = $signed({1'b0, ang_pos}) - $signed({1'b0, FULL_TURN});
        end
    end

    // One CORDIC rotation step.
    logic signed [32:0] xs, ys, cx_step, cy_step, cz_step;
    assign xs = cx_reg >>> cnt_reg[4:0];
    assign ys = cy_reg >>> cnt_reg[4:0];
    always_comb begin
        if (!cz_reg[32]) begin
            cx_step = cx_reg - ys;
            cy_step = cy_reg + xs;
            cz_step = cz_reg - atan_q24(cnt_reg[4:0]);
        end else begin
            cx_step = cx_reg + ys;
            cy_step = cy_reg - xs;
            cz_step = cz_reg + atan_q24(cnt_reg[4:0]);
        end
    end

    // Average of the two sides and signs for the projection.
    logic signed [40:0] side_sum;
    logic signed [39:0] avg;
    logic signed [32:0] cos_v, sin_v;
    assign side_sum = {dl_reg[39], dl_reg} + {dr_reg[39], dr_reg};
    assign avg      = side_sum[40:1];
    assign cos_v    = flip_reg ? -cx_reg : cx_reg;
    assign sin_v    = flip_reg ? -cy_reg : cy_reg;

    // Final rounding of the projection and the saturating updates.
    logic [71:0] rx_full, ry_full;
    logic signed [43:0] rx, ry, new_x, new_y, new_sl, new_sr;
    assign rx_full = prod_x_reg + 72'd536870912;
    assign ry_full = prod_y_reg + 72'd536870912;
    assign rx = negx_reg ? -$signed({2'b00, rx_full[71:30]}) : $signed({2'b00, rx_full[71:30]});
    assign ry = negy_reg ? -$signed({2'b00, ry_full[71:30]}) : $signed({2'b00, ry_full[71:30]});
    assign new_x  = 44'(pos_x_reg) - rx;
    assign new_y  = 44'(pos_y_reg) + ry;
    assign new_sl = 44'(sum_left_reg) + 44'(dl_reg);
    assign new_sr = 44'(sum_right_reg) + 44'(dr_reg);

    logic out_free;
    assign out_free = !out_valid_reg || m_ready;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_mode ? ST_FINISH : ST_SIDE;
                end
            end
            ST_SIDE: begin
                if (cnt_reg == 6'(SCALE_W - 1)) begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (cnt_reg == 6'd6) begin
                    state_next = ST_ROTATE;
                end
            end
            ST_ROTATE: begin
                if (cnt_reg == 6'(CORDIC_RUN - 1)) begin
                    state_next = ST_PROJECT;
                end
            end
            ST_PROJECT: begin
                if (cnt_reg == 6'd31) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers: state, counter, result handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_next != state_reg) begin
                cnt_reg <= 6'd0;
            end else begin
                cnt_reg <= cnt_reg + 6'd1;
            end
            if (state_reg == ST_FINISH && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Architectural state: committed at finish.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_left_reg  <= '0;
            last_right_reg <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            sum_left_reg   <= '0;
            sum_right_reg  <= '0;
        end else if (state_reg == ST_FINISH && out_free) begin
            last_left_reg  <= lat_left_reg;
            last_right_reg <= lat_right_reg;
            if (zero_reg) begin
                pos_x_reg <= '0;
                pos_y_reg <= '0;
            end else begin
                pos_x_reg     <= sat40(new_x);
                pos_y_reg     <= sat40(new_y);
                sum_left_reg  <= sat40(new_sl);
                sum_right_reg <= sat40(new_sr);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                zero_reg      <= s_mode;
                lat_left_reg  <= s_left_encoder;
                lat_right_reg <= s_right_encoder;
                scale_reg     <= s_gear_high ? high_scale_reg : low_scale_reg;
                diff_l_reg    <= 33'(s_left_encoder) - 33'(last_left_reg);
                diff_r_reg    <= 33'(s_right_encoder) - 33'(last_right_reg);
                acc_l_reg     <= '0;
                acc_r_reg     <= '0;
                hneg_reg      <= s_heading_deg[HEAD_W-1];
                hmag_reg      <= s_heading_deg[HEAD_W-1] ?
                                 25'(-26'(s_heading_deg)) : 25'(s_heading_deg);
            end
            ST_SIDE: begin
                // Add one shifted partial product per scale bit.
                if (scale_reg[cnt_reg[4:0]]) begin
                    acc_l_reg <= acc_l_reg + (57'(diff_l_reg) <<< cnt_reg[4:0]);
                    acc_r_reg <= acc_r_reg + (57'(diff_r_reg) <<< cnt_reg[4:0]);
                end
            end
            ST_REDUCE: begin
                if (cnt_reg == 6'd0) begin
                    dl_reg <= sat40(44'(shl));
                    dr_reg <= sat40(44'(shr));
                end
                if (cnt_reg == 6'd6) begin
                    flip_reg <= fold_flip;
                    cz_reg   <= 33'(ang_fold) <<< 16;
                    cx_reg   <= CORDIC_KINV;
                    cy_reg   <= '0;
                end else begin
                    hmag_reg <= ang_mod;
                end
            end
            ST_ROTATE: begin
                cx_reg <= cx_step;
                cy_reg <= cy_step;
                cz_reg <= cz_step;
                if (cnt_reg == 6'(CORDIC_RUN - 1)) begin
                    prod_x_reg <= '0;
                    prod_y_reg <= '0;
                end
            end
            ST_PROJECT: begin
                if (cnt_reg == 6'd0) begin
                    amag_reg <= avg[39] ? 40'(-41'(avg)) : 40'(avg);
                    cmag_reg <= cos_v[32] ? 32'(-cos_v) : 32'(cos_v);
                    smag_reg <= sin_v[32] ? 32'(-sin_v) : 32'(sin_v);
                    negx_reg <= avg[39] != cos_v[32];
                    negy_reg <= avg[39] != sin_v[32];
                    prod_x_reg <= '0;
                    prod_y_reg <= '0;
                end else begin
                    // Bit index is the counter minus one.
                    if (cmag_reg[5'(cnt_reg - 6'd1)]) begin
                        prod_x_reg <= prod_x_reg + (72'(amag_reg) << (cnt_reg - 6'd1));
                    end
                    if (smag_reg[5'(cnt_reg - 6'd1)]) begin
                        prod_y_reg <= prod_y_reg + (72'(amag_reg) << (cnt_reg - 6'd1));
                    end
                end
            end
            ST_FINISH: begin
                // Take the last partial product on entry.
                if (cnt_reg == 6'd0 && !zero_reg) begin
                    if (cmag_reg[31]) begin
                        prod_x_reg <= prod_x_reg + (72'(amag_reg) << 31);
                    end
                    if (smag_reg[31]) begin
                        prod_y_reg <= prod_y_reg + (72'(amag_reg) << 31);
                    end
                end
            end
            default: begin
                zero_reg <= zero_reg;
            end
        endcase
    end

endmodule

// ===== tb/differential_drive_odometry_tb.sv =====
// Testbench for the differential-drive odometry block: directed and random ticks,
// checked against a self-contained predictor held in a small scoreboard class.
// Depends on dd_odom_pkg for field widths and on the block's top level.
module differential_drive_odometry_tb;
    import dd_odom_pkg::*;

    localparam logic [2:0] REG_HIGH = ADDR_HIGH_SCALE;
    localparam logic [2:0] REG_LOW  = ADDR_LOW_SCALE;
    localparam longint     CYCLE_LIMIT = 2000000;
    localparam int         SETTLE = 100;

    typedef struct {
        logic signed [39:0] x;
        logic signed [39:0] y;
        logic signed [39:0] lt;
        logic signed [39:0] rt;
    } pose_t;

    class odometry_scoreboard;
        pose_t  pending[$];
        longint prev_l, prev_r, px, py, tot_l, tot_r;
        longint scale_hi, scale_lo;
        int     errors;
        longint atan_tab[32] = '{
            754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
            15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
            58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
            14, 7, 4, 2, 1, 0};

        function new();
            prev_l = 0; prev_r = 0; px = 0; py = 0; tot_l = 0; tot_r = 0;
            scale_hi = 65536; scale_lo = 65536; errors = 0;
        endfunction

        function longint clamp40(longint v);
            if (v > 64'sd549755813887) return 64'sd549755813887;
            if (v < -64'sd549755813888) return -64'sd549755813888;
            return v;
        endfunction

        // Product over 2^30, rounded half away from zero.
        function longint mul_q30(longint a, longint b);
            logic signed [127:0] p, m;
            p = 128'(a) * 128'(b);
            m = (p < 0) ? -p : p;
            m = (m + (128'sd1 <<< 29)) >>> 30;
            return (p < 0) ? -longint'(m) : longint'(m);
        endfunction

        function void resolve(longint hd, output longint c, output longint s);
            longint a, x, y, z, xs, ys;
            bit     flip;
            flip = 0;
            a = hd % 92160;
            if (a < 0) a += 92160;
            if (a > 23040 && a < 69120) begin
                a -= 46080;
                flip = 1;
            end else if (a >= 69120) begin
                a -= 92160;
            end
            z = a * 65536;
            x = 652032874;
            y = 0;
            for (int i = 0; i < CORDIC_RUN; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= atan_tab[i];
                end else begin
                    x += ys; y -= xs; z += atan_tab[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint wheel_inches(longint now, longint was, longint sc);
            return clamp40(((now - was) * sc + 32768) >>> 16);
        endfunction

        // Advance the predicted pose for one accepted request.
        function void note_request(logic mode, logic signed [31:0] l,
                                   logic signed [31:0] r, logic signed [23:0] hd,
                                   logic gear);
            longint dl, dr, avg, c, s, sc;
            pose_t  e;
            if (mode) begin
                px = 0; py = 0;
            end else begin
                sc = gear ? scale_hi : scale_lo;
                dl = wheel_inches(longint'(l), prev_l, sc);
                dr = wheel_inches(longint'(r), prev_r, sc);
                avg = (dl + dr) >>> 1;
                tot_l = clamp40(tot_l + dl);
                tot_r = clamp40(tot_r + dr);
                resolve(longint'(hd), c, s);
                px = clamp40(px - mul_q30(avg, c));
                py = clamp40(py + mul_q30(avg, s));
            end
            prev_l = longint'(l);
            prev_r = longint'(r);
            e.x = px[39:0]; e.y = py[39:0]; e.lt = tot_l[39:0]; e.rt = tot_r[39:0];
            pending.push_back(e);
        endfunction

        function void check_result(pose_t got);
            pose_t e;
            if (pending.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.x !== e.x) begin
                $error("x_position expected %0d got %0d", e.x, got.x); errors++;
            end
            if (got.y !== e.y) begin
                $error("y_position expected %0d got %0d", e.y, got.y); errors++;
            end
            if (got.lt !== e.lt) begin
                $error("left_total expected %0d got %0d", e.lt, got.lt); errors++;
            end
            if (got.rt !== e.rt) begin
                $error("right_total expected %0d got %0d", e.rt, got.rt); errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready, s_mode, s_gear_high;
    logic signed [31:0] s_left_encoder, s_right_encoder;
    logic signed [23:0] s_heading_deg;
    logic m_valid, m_ready;
    logic signed [39:0] m_x_position, m_y_position, m_left_total, m_right_total;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;

    odometry_scoreboard sb;
    longint cycles;
    bit     hold_req;
    int     enc_l, enc_r;

    differential_drive_odometry uut (.*);

    always begin
        aclk = 1'b1; #4;
        aclk = 1'b0; #4;
    end

    // Sample both channels at the rising edge.
    always @(posedge aclk) begin
        pose_t got;
        if (aresetn && s_valid && s_ready)
            sb.note_request(s_mode, s_left_encoder, s_right_encoder, s_heading_deg,
                            s_gear_high);
        if (aresetn && m_valid && m_ready) begin
            got.x = m_x_position; got.y = m_y_position;
            got.lt = m_left_total; got.rt = m_right_total;
            sb.check_result(got);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("differential_drive_odometry: mismatch");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 20);
    endfunction

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                for (int i = 0; i < 400; i++) @(negedge aclk);
                hold_req = 0;
            end
            n = gap_len();
            if (n == 0) begin
                m_ready = 1'b1;
            end else begin
                m_ready = 1'b0;
                for (int i = 1; i < n; i++) @(negedge aclk);
            end
        end
    end

    task automatic idle_cycles(int n);
        for (int i = 0; i < n; i++) @(negedge aclk);
    endtask

    // Offer one request and hold it until it is taken.
    task automatic send(logic mode, logic signed [31:0] l, logic signed [31:0] r,
                        logic signed [23:0] hd, logic gear);
        s_valid = 1'b1;
        s_mode = mode; s_left_encoder = l; s_right_encoder = r;
        s_heading_deg = hd; s_gear_high = gear;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        enc_l = l; enc_r = r;
        if (gap_len() != 0 || $urandom_range(1)) begin
            s_valid = 1'b0;
            idle_cycles(gap_len());
        end
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        idle_cycles(SETTLE);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (addr == REG_HIGH) sb.scale_hi = data & 32'hFFFFFF;
        else sb.scale_lo = data & 32'hFFFFFF;
    endtask

    // Mostly plausible motion; some wild jumps, zero requests and noise.
    task automatic random_tick();
        int p, step;
        logic signed [31:0] l, r;
        logic signed [23:0] hd;
        p = $urandom_range(99);
        step = (p < 50) ? 1 << 12 : 1 << 20;
        l = enc_l + $signed($urandom_range(2 * step)) - step;
        r = enc_r + $signed($urandom_range(2 * step)) - step;
        hd = (p < 60) ? 24'($signed($urandom_range(200000)) - 100000) : 24'($urandom);
        if (p >= 88) begin
            l = $urandom; r = $urandom;
        end
        send(p >= 96, l, r, hd, 1'($urandom_range(1)));
    endtask

    initial begin
        longint settings[4][2];
        sb = new();
        cycles = 0; hold_req = 0; enc_l = 0; enc_r = 0;
        aresetn = 1'b0;
        s_valid = 1'b0; s_mode = 1'b0; s_left_encoder = '0; s_right_encoder = '0;
        s_heading_deg = '0; s_gear_high = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: reset scales, field extremes, headings on the folds.
        send(1'b0, 32'sh10000, 32'sh20000, 24'sd0, 1'b1);
        send(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 24'sd23040, 1'b0);
        send(1'b0, 32'sh80000000, 32'sh7FFFFFFF, 24'sd46080, 1'b1);
        send(1'b0, 32'sh0, 32'sh0, 24'sh7FFFFF, 1'b0);
        send(1'b0, 32'sh40000, 32'sh40000, 24'sh800000, 1'b1);
        send(1'b0, 32'sh80000, 32'sh80000, 24'sd69120, 1'b0);
        send(1'b0, 32'shC0000, 32'shC0000, -24'sd23041, 1'b1);
        send(1'b1, 32'sh12345, -32'sh54321, 24'sd777, 1'b1);
        send(1'b0, 32'sh22345, -32'sh44321, 24'sd92160, 1'b0);
        drain();

        // Saturate totals and positions with the widest scales.
        apb_write(REG_HIGH, 32'hFFFFFFFF);
        apb_write(REG_LOW, 32'h00FFFFFF);
        for (int i = 0; i < 8; i++) begin
            send(1'b0, (i % 2) ? 32'sh7FFFFFFF : 32'sh80000000,
                 (i % 2) ? 32'sh80000000 : 32'sh7FFFFFFF, 24'sd0, 1'(i % 2));
            send(1'b0, (i % 2) ? 32'sh80000000 : 32'sh7FFFFFFF,
                 (i % 2) ? 32'sh7FFFFFFF : 32'sh80000000, 24'sd23040, 1'b1);
        end
        drain();

        settings = '{'{0, 32'h00FFFFFF}, '{65536, 12345}, '{32'h00FFFFFF, 0},
                     '{0, 0}};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 4) begin
                apb_write(REG_HIGH, 32'(settings[ph][0]));
                apb_write(REG_LOW, 32'(settings[ph][1]));
            end else begin
                apb_write(REG_HIGH, $urandom);
                apb_write(REG_LOW, $urandom_range(1 << 20));
            end
            if (ph == 1) hold_req = 1;
            for (int i = 0; i < 190; i++) random_tick();
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("differential_drive_odometry: match");
        end else begin
            $display("differential_drive_odometry: mismatch");
        end
        $finish;
    end
endmodule
